FILE: hdl/sbe_pkg.sv
`timescale 1ns / 1ps
package sbe_pkg;

  localparam int CMD_W    = 8;
  localparam int IMM_W    = 64;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] OPC_NOP   = 8'd0;
  localparam logic [CMD_W-1:0] OPC_JUMP  = 8'd1;
  localparam logic [CMD_W-1:0] OPC_POP   = 8'd2;
  localparam logic [CMD_W-1:0] OPC_PUSHL = 8'd6;
  localparam logic [CMD_W-1:0] OPC_LOCAL = 8'd10;
  localparam logic [CMD_W-1:0] OPC_COPY  = 8'd14;
  localparam logic [CMD_W-1:0] OPC_STORE = 8'd18;
  localparam logic [CMD_W-1:0] OPC_ADD   = 8'd22;
  localparam logic [CMD_W-1:0] OPC_CJMP  = 8'd26;
  localparam logic [CMD_W-1:0] OPC_OUT   = 8'd27;
  localparam logic [CMD_W-1:0] OPC_EXIT  = 8'd31;

  localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FAULT = 2'd3;

  typedef enum logic [3:0] {
    K_NOP, K_JUMP, K_POP, K_PUSHL, K_LOCAL, K_COPY,
    K_STORE, K_ADD, K_CJMP, K_OUT, K_EXIT, K_BAD
  } op_kind_t;

endpackage

FILE: hdl/sbe_if.sv
`timescale 1ns / 1ps
interface sbe_instr_if;
  logic                           valid;
  logic                           ready;
  logic [sbe_pkg::CMD_W-1:0]      cmd;
  logic [sbe_pkg::IMM_W-1:0]      immediate;
  logic [sbe_pkg::ADDR_W-1:0]     instr_addr;
  modport source (output valid, cmd, immediate, instr_addr, input ready);
  modport sink (input valid, cmd, immediate, instr_addr, output ready);
endinterface

interface sbe_result_if;
  logic                           valid;
  logic                           ready;
  logic [sbe_pkg::ADDR_W-1:0]     next_addr;
  logic                           print_valid;
  logic signed [63:0]             print_value;
  logic [sbe_pkg::STATUS_W-1:0]   run_status;
  modport source (output valid, next_addr, print_valid, print_value, run_status,
                  input ready);
  modport sink (input valid, next_addr, print_valid, print_value, run_status,
                output ready);
endinterface

FILE: hdl/stack_bytecode_executor.sv
`timescale 1ns / 1ps
// Stack bytecode executor.
// The instr channel takes one decoded instruction per transaction (cmd,
// immediate, instr_addr). The result channel returns exactly one transaction
// per instruction: next_addr, print_valid/print_value and run_status.
// The stack is held in eight byte-wide banks; byte address a lives in bank
// a[2:0], row a>>3, so any access of up to eight bytes touches each bank once.
// Each bank has two read ports, which serve the two operands of an add.
// An instruction is decoded and its stack pointer update and fault check are
// done in the accept cycle while the banks are read; in the data stage that
// follows, the data is combined, written back and the result registered.
// One instruction is accepted per cycle while the result receiver keeps up.
// A write from the instruction ahead is forwarded per bank to the
// one behind it, so back-to-back dependent instructions need no bubble.
// After reset the stack is zeroed by a clearing pass over every row of the
// banks, during which instr.ready stays low.
// When the result receiver stalls, the finished result waits in the output
// register, one more instruction waits in the read stage, and then
// instr.ready drops until the result is taken.
module stack_bytecode_executor #(
  parameter int STACK_BYTES = 1048576
) (
  input  logic         clk,
  input  logic         rst,
  sbe_instr_if.sink    instr,
  sbe_result_if.source result
);

  localparam int AW = $clog2(STACK_BYTES);
  localparam int TW = AW + 1;
  localparam int RW = AW - 3;
  localparam int ROWS = STACK_BYTES / 8;
  localparam logic [TW-1:0] STACK_SIZE = TW'(STACK_BYTES);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  // Clearing pass.
  logic          clearing;
  logic [RW-1:0] clr_row;

  logic [TW-1:0] top;

  // Decode of the incoming instruction.
  sbe_pkg::op_kind_t kind;
  logic [1:0]        sz;
  logic [3:0]        nb4;
  logic [TW-1:0]     nb, off_ext, top_next;
  logic [TW-1:0]     rd0_pos, rd1_pos, wr_pos;
  logic              fault, wr_en;
  logic [15:0]       off, next_addr_d;
  logic [1:0]        status_d;
  logic [RW-1:0]     rd0_row [8];
  logic [RW-1:0]     rd1_row [8];
  logic [RW-1:0]     wr_row [8];
  logic [7:0]        wr_mask;

  // Read stage registers.
  logic              s1_valid, s1_done, accept;
  sbe_pkg::op_kind_t s1_kind;
  logic [1:0]        s1_sz;
  logic              s1_fault, s1_wr_en;
  logic [15:0]       s1_next, s1_off;
  logic [1:0]        s1_status;
  logic [63:0]       s1_imm;
  logic [2:0]        s1_rd0_lo, s1_rd1_lo, s1_wr_lo;
  logic [RW-1:0]     s1_rd0_row [8];
  logic [RW-1:0]     s1_rd1_row [8];
  logic [RW-1:0]     s1_wr_row [8];
  logic [7:0]        s1_wr_mask;

  // Last write, forwarded per bank.
  logic [7:0]        fwd_en;
  logic [RW-1:0]     fwd_row [8];
  logic [7:0]        fwd_data [8];

  // Bank ports.
  logic [7:0]        bank_we;
  logic [RW-1:0]     bank_waddr [8];
  logic [7:0]        bank_wdata [8];
  logic [7:0]        rdata0 [8];
  logic [7:0]        rdata1 [8];

  // Data stage.
  logic [7:0]        raw0 [8];
  logic [7:0]        raw1 [8];
  logic [63:0]       win0, win1, wval, pval;
  logic [7:0]        wbyte [8];
  logic [15:0]       res_next;

  assign s1_done = s1_valid && (!result.valid || result.ready);
  assign instr.ready = !clearing && (!s1_valid || s1_done);
  assign accept = instr.valid && instr.ready;

  always_comb begin
    kind = sbe_pkg::K_BAD;
    sz = 2'd0;
    priority if (instr.cmd == sbe_pkg::OPC_NOP) begin
      kind = sbe_pkg::K_NOP;
    end else if (instr.cmd == sbe_pkg::OPC_JUMP) begin
      kind = sbe_pkg::K_JUMP;
    end else if (instr.cmd >= sbe_pkg::OPC_POP && instr.cmd < sbe_pkg::OPC_PUSHL) begin
      kind = sbe_pkg::K_POP;
      sz = 2'(instr.cmd - sbe_pkg::OPC_POP);
    end else if (instr.cmd >= sbe_pkg::OPC_PUSHL && instr.cmd < sbe_pkg::OPC_LOCAL) begin
      kind = sbe_pkg::K_PUSHL;
      sz = 2'(instr.cmd - sbe_pkg::OPC_PUSHL);
    end else if (instr.cmd >= sbe_pkg::OPC_LOCAL && instr.cmd < sbe_pkg::OPC_COPY) begin
      kind = sbe_pkg::K_LOCAL;
      sz = 2'(instr.cmd - sbe_pkg::OPC_LOCAL);
    end else if (instr.cmd >= sbe_pkg::OPC_COPY && instr.cmd < sbe_pkg::OPC_STORE) begin
      kind = sbe_pkg::K_COPY;
      sz = 2'(instr.cmd - sbe_pkg::OPC_COPY);
    end else if (instr.cmd >= sbe_pkg::OPC_STORE && instr.cmd < sbe_pkg::OPC_ADD) begin
      kind = sbe_pkg::K_STORE;
      sz = 2'(instr.cmd - sbe_pkg::OPC_STORE);
    end else if (instr.cmd >= sbe_pkg::OPC_ADD && instr.cmd < sbe_pkg::OPC_CJMP) begin
      kind = sbe_pkg::K_ADD;
      sz = 2'(instr.cmd - sbe_pkg::OPC_ADD);
    end else if (instr.cmd == sbe_pkg::OPC_CJMP) begin
      kind = sbe_pkg::K_CJMP;
      sz = 2'd3;
    end else if (instr.cmd >= sbe_pkg::OPC_OUT && instr.cmd < sbe_pkg::OPC_EXIT) begin
      kind = sbe_pkg::K_OUT;
      sz = 2'(instr.cmd - sbe_pkg::OPC_OUT);
    end else if (instr.cmd == sbe_pkg::OPC_EXIT) begin
      kind = sbe_pkg::K_EXIT;
    end else begin
      kind = sbe_pkg::K_BAD;
    end
  end

  always_comb begin
    logic lt_n, over_top, over_off;
    logic [2:0] k;
    nb4 = 4'd1 << sz;
    nb = TW'(nb4);
    off = instr.immediate[15:0];
    off_ext = TW'(off);
    lt_n = top < nb;
    over_top = top > STACK_SIZE - nb;
    over_off = off_ext > STACK_SIZE - nb;
    fault = 1'b0;
    wr_en = 1'b0;
    top_next = top;
    rd0_pos = top - nb;
    rd1_pos = top - (nb << 1);
    wr_pos = top;
    next_addr_d = instr.instr_addr + 16'd1;
    status_d = sbe_pkg::ST_RUN;
    unique case (kind)
      sbe_pkg::K_NOP: ;
      sbe_pkg::K_JUMP: next_addr_d = off - 16'd1;
      sbe_pkg::K_POP, sbe_pkg::K_OUT: begin
        fault = lt_n;
        top_next = top - nb;
      end
      sbe_pkg::K_PUSHL: begin
        fault = over_top;
        wr_en = 1'b1;
        top_next = top + nb;
        next_addr_d = instr.instr_addr + 16'd1 + 16'(nb4);
      end
      sbe_pkg::K_LOCAL: begin
        fault = over_top || over_off;
        wr_en = 1'b1;
        rd0_pos = off_ext;
        top_next = top + nb;
        next_addr_d = instr.instr_addr + 16'd3;
      end
      sbe_pkg::K_COPY: begin
        fault = lt_n || over_top;
        wr_en = 1'b1;
        top_next = top + nb;
      end
      sbe_pkg::K_STORE: begin
        fault = lt_n || over_off;
        wr_en = 1'b1;
        wr_pos = off_ext;
        top_next = top - nb;
        next_addr_d = instr.instr_addr + 16'd3;
      end
      sbe_pkg::K_ADD: begin
        fault = top < (nb << 1);
        wr_en = 1'b1;
        wr_pos = top - (nb << 1);
        top_next = top - nb;
      end
      sbe_pkg::K_CJMP: begin
        fault = lt_n;
        rd0_pos = top - nb;
        top_next = top - nb;
        next_addr_d = instr.instr_addr + 16'd3;
      end
      sbe_pkg::K_EXIT: begin
        next_addr_d = instr.instr_addr;
        status_d = sbe_pkg::ST_EXIT;
      end
      sbe_pkg::K_BAD: begin
        next_addr_d = instr.instr_addr;
        status_d = sbe_pkg::ST_BAD;
      end
      default: status_d = sbe_pkg::ST_BAD;
    endcase
    if (fault) begin
      wr_en = 1'b0;
      top_next = top;
      next_addr_d = instr.instr_addr;
      status_d = sbe_pkg::ST_FAULT;
    end
    // Banks below the start offset hold bytes of the following row.
    for (int b = 0; b < 8; b++) begin
      rd0_row[b] = rd0_pos[AW-1:3] + RW'(3'(b) < rd0_pos[2:0]);
      rd1_row[b] = rd1_pos[AW-1:3] + RW'(3'(b) < rd1_pos[2:0]);
      wr_row[b] = wr_pos[AW-1:3] + RW'(3'(b) < wr_pos[2:0]);
      k = 3'(b) - wr_pos[2:0];
      wr_mask[b] = {1'b0, k} < nb4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row <= '0;
      top <= '0;
      s1_valid <= 1'b0;
      fwd_en <= '0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + RW'(1);
        if (clr_row == LAST_ROW) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        top <= top_next;
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        for (int b = 0; b < 8; b++) begin
          fwd_en[b] <= s1_wr_en && s1_wr_mask[b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= kind;
      s1_sz <= sz;
      s1_fault <= fault;
      s1_wr_en <= wr_en;
      s1_next <= next_addr_d;
      s1_off <= off;
      s1_status <= status_d;
      s1_imm <= instr.immediate;
      s1_rd0_lo <= rd0_pos[2:0];
      s1_rd1_lo <= rd1_pos[2:0];
      s1_wr_lo <= wr_pos[2:0];
      s1_wr_mask <= wr_mask;
      s1_rd0_row <= rd0_row;
      s1_rd1_row <= rd1_row;
      s1_wr_row <= wr_row;
    end
    if (s1_done) begin
      fwd_row <= s1_wr_row;
      fwd_data <= wbyte;
    end
  end

  // Data stage: forward, align, compute.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      raw0[b] = (fwd_en[b] && fwd_row[b] == s1_rd0_row[b]) ? fwd_data[b] : rdata0[b];
      raw1[b] = (fwd_en[b] && fwd_row[b] == s1_rd1_row[b]) ? fwd_data[b] : rdata1[b];
    end
    for (int k = 0; k < 8; k++) begin
      win0[8*k +: 8] = raw0[3'(s1_rd0_lo + 3'(k))];
      win1[8*k +: 8] = raw1[3'(s1_rd1_lo + 3'(k))];
    end
    unique case (s1_kind)
      sbe_pkg::K_PUSHL: wval = s1_imm;
      sbe_pkg::K_ADD:   wval = win0 + win1;
      default:          wval = win0;
    endcase
    for (int b = 0; b < 8; b++) begin
      wbyte[b] = wval[8*(3'(3'(b) - s1_wr_lo)) +: 8];
    end
    unique case (s1_sz)
      2'd0: pval = {{56{win0[7]}}, win0[7:0]};
      2'd1: pval = {{48{win0[15]}}, win0[15:0]};
      2'd2: pval = {{32{win0[31]}}, win0[31:0]};
      2'd3: pval = win0;
      default: pval = win0;
    endcase
    res_next = s1_next;
    // Compare-jump window: a in the lower word, b in the upper word.
    if (s1_kind == sbe_pkg::K_CJMP && !s1_fault && win0[31:0] >= win0[63:32]) begin
      res_next = s1_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      result.next_addr <= res_next;
      result.run_status <= s1_status;
      result.print_valid <= s1_kind == sbe_pkg::K_OUT && !s1_fault;
      result.print_value <= (s1_kind == sbe_pkg::K_OUT && !s1_fault) ? pval : '0;
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      if (clearing) begin
        bank_we[b] = 1'b1;
        bank_waddr[b] = clr_row;
        bank_wdata[b] = 8'd0;
      end else begin
        bank_we[b] = s1_done && s1_wr_en && s1_wr_mask[b];
        bank_waddr[b] = s1_wr_row[b];
        bank_wdata[b] = wbyte[b];
      end
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_bank
    sbe_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk    (clk),
      .we     (bank_we[g]),
      .waddr  (bank_waddr[g]),
      .wdata  (bank_wdata[g]),
      .re     (accept),
      .raddr0 (rd0_row[g]),
      .raddr1 (rd1_row[g]),
      .rdata0 (rdata0[g]),
      .rdata1 (rdata1[g])
    );
  end

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    top <= STACK_SIZE)
    else $error("stack pointer beyond stack size");

  a_fault_keeps_top: assert property (@(posedge clk) disable iff (rst)
    accept && fault |=> top == $past(top))
    else $error("faulting instruction moved the stack pointer");

  a_print_only_running: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.print_valid |-> result.run_status == sbe_pkg::ST_RUN)
    else $error("print value reported with a halt status");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("instruction accepted during clearing pass");

endmodule

FILE: hdl/sbe_ram.sv
`timescale 1ns / 1ps
module sbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: test/tb_stack_bytecode_executor.sv
`timescale 1ns / 1ps
module tb_stack_bytecode_executor;

  localparam int MEM_BYTES = 1048576;
  localparam int WATCH_LIMIT = 400000;

  typedef struct packed {
    logic [sbe_pkg::ADDR_W-1:0]   next_addr;
    logic                         print_valid;
    logic [63:0]                  print_value;
    logic [sbe_pkg::STATUS_W-1:0] run_status;
  } outcome_t;

  logic clk;
  logic rst;
  sbe_instr_if  instr ();
  sbe_result_if result ();

  stack_bytecode_executor uut (.clk(clk), .rst(rst), .instr(instr), .result(result));

  logic [7:0] shadow_mem [int];
  int unsigned shadow_top;
  outcome_t pending_outcomes[$];
  int error_count;
  int watch_count;
  bit hold_result;
  bit no_idle;
  logic [sbe_pkg::ADDR_W-1:0] pc;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] mem_byte(int unsigned a);
    if (shadow_mem.exists(a)) return shadow_mem[a];
    return 8'h00;
  endfunction

  function automatic logic [63:0] mem_get(int unsigned a, int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = mem_byte(a + i);
    return v;
  endfunction

  function automatic void mem_put(int unsigned a, int unsigned n, logic [63:0] v);
    for (int i = 0; i < n; i++) shadow_mem[a + i] = v[8*i +: 8];
  endfunction

  function automatic logic [63:0] width_mask(int unsigned n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // Computes the executor's response to one instruction and updates the shadow stack.
  function automatic outcome_t execute_instr(logic [7:0] c, logic [63:0] imm,
                                             logic [15:0] ia);
    outcome_t o;
    int unsigned n, top, off;
    logic [63:0] a, b;
    bit fault;
    n = 1; top = shadow_top; off = 32'(imm[15:0]); fault = 0;
    o.next_addr = ia + 16'd1; o.print_valid = 0; o.print_value = '0;
    o.run_status = sbe_pkg::ST_RUN;
    if (c == sbe_pkg::OPC_NOP) begin
    end else if (c == sbe_pkg::OPC_JUMP) begin
      o.next_addr = imm[15:0] - 16'd1;
    end else if (c >= sbe_pkg::OPC_POP && c < sbe_pkg::OPC_PUSHL) begin
      n = 1 << (c - sbe_pkg::OPC_POP);
      if (top < n) fault = 1; else shadow_top = top - n;
    end else if (c >= sbe_pkg::OPC_PUSHL && c < sbe_pkg::OPC_LOCAL) begin
      n = 1 << (c - sbe_pkg::OPC_PUSHL);
      if (top > MEM_BYTES - n) fault = 1;
      else begin
        mem_put(top, n, imm); shadow_top = top + n; o.next_addr = ia + 16'(1 + n);
      end
    end else if (c >= sbe_pkg::OPC_LOCAL && c < sbe_pkg::OPC_COPY) begin
      n = 1 << (c - sbe_pkg::OPC_LOCAL);
      if (top > MEM_BYTES - n || off > MEM_BYTES - n) fault = 1;
      else begin
        mem_put(top, n, mem_get(off, n)); shadow_top = top + n; o.next_addr = ia + 16'd3;
      end
    end else if (c >= sbe_pkg::OPC_COPY && c < sbe_pkg::OPC_STORE) begin
      n = 1 << (c - sbe_pkg::OPC_COPY);
      if (top < n || top > MEM_BYTES - n) fault = 1;
      else begin
        mem_put(top, n, mem_get(top - n, n)); shadow_top = top + n;
      end
    end else if (c >= sbe_pkg::OPC_STORE && c < sbe_pkg::OPC_ADD) begin
      n = 1 << (c - sbe_pkg::OPC_STORE);
      if (top < n || off > MEM_BYTES - n) fault = 1;
      else begin
        a = mem_get(top - n, n); shadow_top = top - n; mem_put(off, n, a);
        o.next_addr = ia + 16'd3;
      end
    end else if (c >= sbe_pkg::OPC_ADD && c < sbe_pkg::OPC_CJMP) begin
      n = 1 << (c - sbe_pkg::OPC_ADD);
      if (top < 2 * n) fault = 1;
      else begin
        a = mem_get(top - n, n); b = mem_get(top - 2 * n, n);
        mem_put(top - 2 * n, n, (a + b) & width_mask(n)); shadow_top = top - n;
      end
    end else if (c == sbe_pkg::OPC_CJMP) begin
      if (top < 8) fault = 1;
      else begin
        b = mem_get(top - 4, 4); a = mem_get(top - 8, 4); shadow_top = top - 8;
        o.next_addr = (a >= b) ? imm[15:0] : ia + 16'd3;
      end
    end else if (c >= sbe_pkg::OPC_OUT && c < sbe_pkg::OPC_EXIT) begin
      n = 1 << (c - sbe_pkg::OPC_OUT);
      if (top < n) fault = 1;
      else begin
        a = mem_get(top - n, n);
        if (n < 8 && a[8*n-1]) a = a | ~width_mask(n);
        o.print_value = a; o.print_valid = 1; shadow_top = top - n;
      end
    end else if (c == sbe_pkg::OPC_EXIT) begin
      o.run_status = sbe_pkg::ST_EXIT; o.next_addr = ia;
    end else begin
      o.run_status = sbe_pkg::ST_BAD; o.next_addr = ia;
    end
    if (fault) begin
      o.run_status = sbe_pkg::ST_FAULT; o.next_addr = ia; o.print_valid = 0;
      o.print_value = '0;
    end
    return o;
  endfunction

  task automatic issue_instr(logic [7:0] c, logic [63:0] imm, logic [15:0] ia);
    while (!no_idle && $urandom_range(99) < 18) begin
      instr.valid <= 1'b0;
      @(posedge clk);
    end
    instr.valid <= 1'b1;
    instr.cmd <= c;
    instr.immediate <= imm;
    instr.instr_addr <= ia;
    do @(posedge clk); while (!instr.ready);
    pending_outcomes.push_back(execute_instr(c, imm, ia));
  endtask

  // Follows the predicted next_addr so that issued addresses look like a real program.
  task automatic run_op(logic [7:0] c, logic [63:0] imm);
    issue_instr(c, imm, pc);
    pc = pending_outcomes[$].next_addr;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= !hold_result && (no_idle || $urandom_range(99) >= 18);
      if (result.valid && result.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("unexpected result transaction");
          error_count++;
        end else begin
          outcome_t e;
          e = pending_outcomes.pop_front();
          if (result.next_addr !== e.next_addr) begin
            $error("next_addr exp %h got %h", e.next_addr, result.next_addr);
            error_count++;
          end
          if (result.print_valid !== e.print_valid) begin
            $error("print_valid exp %b got %b", e.print_valid, result.print_valid);
            error_count++;
          end
          if (result.print_value !== e.print_value) begin
            $error("print_value exp %h got %h", e.print_value, result.print_value);
            error_count++;
          end
          if (result.run_status !== e.run_status) begin
            $error("run_status exp %0d got %0d", e.run_status, result.run_status);
            error_count++;
          end
        end
      end
    end
  end

  // The clearing pass after reset keeps ready low; the watchdog counts through it, so its limit lies above the pass.
  always @(posedge clk) begin
    if (rst || (instr.valid && instr.ready) || (result.valid && result.ready)
        || (!instr.valid && pending_outcomes.size() == 0)) begin
      watch_count <= 0;
    end else begin
      watch_count <= watch_count + 1;
      if (watch_count > WATCH_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_directed();
    pc = 16'h0000;
    run_op(sbe_pkg::OPC_NOP, 64'd0);
    run_op(sbe_pkg::OPC_POP, 64'd0);                 // underflow on empty stack
    run_op(sbe_pkg::OPC_OUT + 8'd3, 64'd0);
    run_op(sbe_pkg::OPC_PUSHL + 8'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    run_op(sbe_pkg::OPC_PUSHL + 8'd3, 64'h8000_0000_0000_0001);
    run_op(sbe_pkg::OPC_ADD + 8'd3, 64'd0);
    run_op(sbe_pkg::OPC_COPY + 8'd3, 64'd0);
    run_op(sbe_pkg::OPC_OUT + 8'd3, 64'd0);
    run_op(sbe_pkg::OPC_PUSHL, 64'h80);
    run_op(sbe_pkg::OPC_OUT, 64'd0);
    run_op(sbe_pkg::OPC_PUSHL + 8'd1, 64'h1234_8001);
    run_op(sbe_pkg::OPC_STORE + 8'd1, 64'd40);
    run_op(sbe_pkg::OPC_LOCAL + 8'd1, 64'd40);
    run_op(sbe_pkg::OPC_OUT + 8'd1, 64'd0);
    run_op(sbe_pkg::OPC_PUSHL + 8'd2, 64'hFFFF_FFFF);
    run_op(sbe_pkg::OPC_PUSHL + 8'd2, 64'd0);
    run_op(sbe_pkg::OPC_CJMP, 64'h00F0);
    run_op(sbe_pkg::OPC_JUMP, 64'h0000);             // target wraps to 0xFFFF
    run_op(sbe_pkg::OPC_LOCAL + 8'd3, 64'hFFFF);
    run_op(sbe_pkg::OPC_STORE, 64'hFFFF);
    run_op(sbe_pkg::OPC_EXIT, 64'd0);
    run_op(8'd32, 64'd0);
    run_op(8'hFF, rand64());
    run_op(sbe_pkg::OPC_ADD, 64'd0);
  endtask

  task automatic test_random(int count);
    logic [7:0] c;
    int r;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= 300 && i < 500);
      r = $urandom_range(99);
      if (r < 4) c = 8'($urandom_range(32, 255));
      else if (r < 10) c = 8'($urandom_range(0, 31));
      else if (r < 40) c = sbe_pkg::OPC_PUSHL + 8'($urandom_range(3));
      else if (r < 50) c = sbe_pkg::OPC_LOCAL + 8'($urandom_range(3));
      else if (r < 58) c = sbe_pkg::OPC_STORE + 8'($urandom_range(3));
      else if (r < 68) c = sbe_pkg::OPC_ADD + 8'($urandom_range(3));
      else if (r < 74) c = sbe_pkg::OPC_COPY + 8'($urandom_range(3));
      else if (r < 78) c = sbe_pkg::OPC_CJMP;
      else if (r < 93) c = sbe_pkg::OPC_OUT + 8'($urandom_range(3));
      else c = sbe_pkg::OPC_POP + 8'($urandom_range(3));
      // Mostly small local offsets so stores and loads meet; some span the full range.
      issue_instr(c, ($urandom_range(3) == 0) ? rand64()
                  : {48'(rand64() >> 16), 16'($urandom_range(0, 255))}, 16'($urandom));
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_result = 1;
        repeat (60) @(posedge clk);
        hold_result = 0;
      end
      for (int i = 0; i < 20; i++)
        issue_instr(sbe_pkg::OPC_PUSHL + 8'($urandom_range(3)), rand64(), 16'($urandom));
    join
  endtask

  initial begin
    error_count = 0; hold_result = 0; no_idle = 0;
    rst = 1'b1;
    instr.valid = 1'b0; instr.cmd = '0; instr.immediate = '0; instr.instr_addr = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(1500);
    instr.valid <= 1'b0;
    wait (pending_outcomes.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
